// ===== rtl/stroke_shape_classifier_core_assert.svh =====
// assertion macros used by ssc_dp
`ifndef STROKE_SHAPE_CLASSIFIER_CORE_ASSERT_SVH
`define STROKE_SHAPE_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define SSC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

   localparam int COORD_BITS = 12;
   localparam int MODE_W     = 2;
   localparam int CLASS_W    = 4;
   localparam int TOTAL_W    = 4;
   localparam int CFG_W      = 12;
   localparam int COS_W      = 16;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 5;

   localparam int DEF_POINT_CAPACITY = 2048;
   localparam int DEF_CORNER_SPAN    = 10;
   localparam int DEF_CORNER_LIMIT   = 10;

   // squared lengths, dot products and the shared multiplier
   localparam int SQ_W   = 2 * COORD_BITS + 2;
   localparam int DOT_W  = SQ_W + 1;
   localparam int MUL_W  = DOT_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CMP_W  = 2 * SQ_W + COS_W;

   localparam logic [MODE_W-1:0] MODE_DOWN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UP    = 2'd2;

   localparam logic [2:0] REG_CLOSE  = 3'd0;
   localparam logic [2:0] REG_MINPTS = 3'd1;
   localparam logic [2:0] REG_COS    = 3'd2;
   localparam logic [2:0] REG_SQTOL  = 3'd3;
   localparam logic [2:0] REG_ROUND  = 3'd4;

   localparam logic [CFG_W-1:0] RST_CLOSE  = 12'd30;
   localparam logic [CFG_W-1:0] RST_MINPTS = 12'd20;
   localparam logic [COS_W-1:0] RST_COS    = 16'd53831;
   localparam logic [CFG_W-1:0] RST_SQTOL  = 12'd40;
   localparam logic [CFG_W-1:0] RST_ROUND  = 12'd50;

   typedef enum logic [CLASS_W-1:0] {
      CLS_TOO_SHORT      = 4'd0,
      CLS_TRIANGLE       = 4'd1,
      CLS_SQUARE         = 4'd2,
      CLS_RECT_RHOMBUS   = 4'd3,
      CLS_PENTAGON       = 4'd4,
      CLS_UNKNOWN_CLOSED = 4'd5,
      CLS_LETTER_I       = 4'd6,
      CLS_Z_DASH         = 4'd7,
      CLS_LETTER_O       = 4'd8,
      CLS_UNKNOWN_OPEN   = 4'd9
   } class_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [CFG_W-1:0] close_distance;
      logic [CFG_W-1:0] min_points;
      logic [COS_W-1:0] corner_cos_sq_q16;
      logic [CFG_W-1:0] square_tolerance;
      logic [CFG_W-1:0] round_min_size;
   } cfg_type;

   typedef enum logic [1:0] {RD_A, RD_B, RD_LAST} rd_sel_type;

   typedef enum logic [4:0] {
      MUL_NONE, MUL_UXUX, MUL_UYUY, MUL_VXVX, MUL_VYVY, MUL_UXVX, MUL_UYVY,
      MUL_UUVV, MUL_MAGMAG, MUL_PLO_COS, MUL_PHI_COS, MUL_D02X, MUL_D02Y,
      MUL_D13X, MUL_D13Y, MUL_TT, MUL_DD, MUL_T2Q, MUL_CLX, MUL_CLY, MUL_CDCD
   } mul_sel_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_S0_LD, DST_S0_ADD, DST_S1_LD, DST_S1_ADD, DST_S2_LD,
      DST_S2_ADD, DST_P_LD, DST_LHS_LD16, DST_LHS_LD, DST_RHS_LD,
      DST_RHS_ADD_HI, DST_RHS_LD4
   } dst_type;

   typedef enum logic [1:0] {CSEL_SHORT, CSEL_GEOM, CSEL_QUAD} cls_sel_type;

   typedef struct packed {
      logic        clear;
      logic        add;
      logic        pen_up;
      rd_sel_type  rd_sel;
      logic        ld_a;
      logic        ld_b;
      mul_sel_type mul_sel;
      dst_type     dst;
      logic        corner_eval;
      logic        set_class;
      cls_sel_type cls_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic pen_active;
      logic can_add;
      logic span_full;
      logic tally_open;
      logic too_short;
      logic closed;
      logic four_corners;
   } dp_status_type;

endpackage

// ===== rtl/ssc_intf.sv =====
interface ssc_req_if import ssc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [COORD_BITS-1:0] x_coord;
   logic [COORD_BITS-1:0] y_coord;

   modport source (output valid, mode, x_coord, y_coord, input ready);
   modport sink (input valid, mode, x_coord, y_coord, output ready);
endinterface

interface ssc_rsp_if import ssc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] shape_class;
   logic [TOTAL_W-1:0] corner_total;

   modport source (output valid, shape_class, corner_total, input ready);
   modport sink (input valid, shape_class, corner_total, output ready);
endinterface

// ===== rtl/stroke_shape_classifier_core.sv =====
// Stroke shape classifier: pen events arrive on req_if (pen down, motion point,
// pen up) and each pen up returns one transfer on rsp_if with the shape class
// and the capped corner count. Items are handled one at a time. A motion point
// from the (2*CORNER_SPAN+1)-th on, while the corner count is below its limit,
// starts a corner test: two reads of the point ring and ten passes through the
// one shared 27x27 multiplier. A pen up on a stroke that is not too short runs
// the closed test, then the square test on a closed four-corner stroke; the
// result then waits in its register until taken. Registers sit on the csr_ APB
// port at 4-byte strides.
module stroke_shape_classifier_core import ssc_pkg::*; #(
   parameter int POINT_CAPACITY = DEF_POINT_CAPACITY,
   parameter int CORNER_SPAN    = DEF_CORNER_SPAN,
   parameter int CORNER_LIMIT   = DEF_CORNER_LIMIT
) (
   input  logic              clock,
   input  logic              reset,
   ssc_req_if.sink           req_if,
   ssc_rsp_if.source         rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   ssc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssc_dp #(
      .POINT_CAPACITY (POINT_CAPACITY),
      .CORNER_SPAN    (CORNER_SPAN),
      .CORNER_LIMIT   (CORNER_LIMIT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .x_coord      (req_if.x_coord),
      .y_coord      (req_if.y_coord),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .shape_class  (rsp_if.shape_class),
      .corner_total (rsp_if.corner_total)
   );

endmodule

// ===== rtl/ssc_csr.sv =====
module ssc_csr import ssc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.close_distance    <= RST_CLOSE;
         cfg_ff.min_points        <= RST_MINPTS;
         cfg_ff.corner_cos_sq_q16 <= RST_COS;
         cfg_ff.square_tolerance  <= RST_SQTOL;
         cfg_ff.round_min_size    <= RST_ROUND;
      end else if (wr_en) begin
         unique case (index)
            REG_CLOSE:  cfg_ff.close_distance    <= csr_pwdata[CFG_W-1:0];
            REG_MINPTS: cfg_ff.min_points        <= csr_pwdata[CFG_W-1:0];
            REG_COS:    cfg_ff.corner_cos_sq_q16 <= csr_pwdata[COS_W-1:0];
            REG_SQTOL:  cfg_ff.square_tolerance  <= csr_pwdata[CFG_W-1:0];
            REG_ROUND:  cfg_ff.round_min_size    <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_CLOSE:  csr_prdata = DATA_W'(cfg_ff.close_distance);
         REG_MINPTS: csr_prdata = DATA_W'(cfg_ff.min_points);
         REG_COS:    csr_prdata = DATA_W'(cfg_ff.corner_cos_sq_q16);
         REG_SQTOL:  csr_prdata = DATA_W'(cfg_ff.square_tolerance);
         REG_ROUND:  csr_prdata = DATA_W'(cfg_ff.round_min_size);
         default:    csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/ssc_ctrl.sv =====
module ssc_ctrl import ssc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dp_status_type     status,
   output dp_cmd_type        cmd
);

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_C_RA, ST_C_RB, ST_C_LB,
      ST_C_M0, ST_C_M1, ST_C_M2, ST_C_M3, ST_C_M4, ST_C_M5, ST_C_M6,
      ST_C_M7, ST_C_M8, ST_C_M9, ST_C_M10, ST_C_DEC,
      ST_K_RL, ST_K_LL, ST_K_M0, ST_K_M1, ST_K_M2, ST_K_M3, ST_K_DEC,
      ST_Q_M0, ST_Q_M1, ST_Q_M2, ST_Q_M3, ST_Q_M4, ST_Q_M5, ST_Q_M6,
      ST_Q_M7, ST_Q_M8, ST_Q_DEC,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.clear       = 1'b0;
      cmd.add         = 1'b0;
      cmd.pen_up      = 1'b0;
      cmd.rd_sel      = RD_A;
      cmd.ld_a        = 1'b0;
      cmd.ld_b        = 1'b0;
      cmd.mul_sel     = MUL_NONE;
      cmd.dst         = DST_NONE;
      cmd.corner_eval = 1'b0;
      cmd.set_class   = 1'b0;
      cmd.cls_sel     = CSEL_GEOM;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_DOWN: cmd.clear = 1'b1;
                  MODE_POINT: begin
                     if (status.pen_active && status.can_add) begin
                        cmd.add = 1'b1;
                        if (status.span_full && status.tally_open) begin
                           state_in = ST_C_RA;
                        end
                     end
                  end
                  MODE_UP: begin
                     cmd.pen_up = 1'b1;
                     if (status.too_short) begin
                        cmd.set_class = 1'b1;
                        cmd.cls_sel   = CSEL_SHORT;
                        state_in      = ST_OUT;
                     end else begin
                        state_in = ST_K_RL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // corner test on the point one span back
         ST_C_RA: begin
            cmd.rd_sel = RD_A;
            state_in   = ST_C_RB;
         end
         ST_C_RB: begin
            cmd.rd_sel = RD_B;
            cmd.ld_a   = 1'b1;
            state_in   = ST_C_LB;
         end
         ST_C_LB: begin
            cmd.ld_b = 1'b1;
            state_in = ST_C_M0;
         end
         ST_C_M0: begin
            cmd.mul_sel = MUL_UXUX;
            state_in    = ST_C_M1;
         end
         ST_C_M1: begin
            cmd.mul_sel = MUL_UYUY;
            cmd.dst     = DST_S0_LD;
            state_in    = ST_C_M2;
         end
         ST_C_M2: begin
            cmd.mul_sel = MUL_VXVX;
            cmd.dst     = DST_S0_ADD;
            state_in    = ST_C_M3;
         end
         ST_C_M3: begin
            cmd.mul_sel = MUL_VYVY;
            cmd.dst     = DST_S1_LD;
            state_in    = ST_C_M4;
         end
         ST_C_M4: begin
            cmd.mul_sel = MUL_UXVX;
            cmd.dst     = DST_S1_ADD;
            state_in    = ST_C_M5;
         end
         ST_C_M5: begin
            cmd.mul_sel = MUL_UYVY;
            cmd.dst     = DST_S2_LD;
            state_in    = ST_C_M6;
         end
         ST_C_M6: begin
            cmd.mul_sel = MUL_UUVV;
            cmd.dst     = DST_S2_ADD;
            state_in    = ST_C_M7;
         end
         ST_C_M7: begin
            cmd.mul_sel = MUL_MAGMAG;
            cmd.dst     = DST_P_LD;
            state_in    = ST_C_M8;
         end
         ST_C_M8: begin
            cmd.mul_sel = MUL_PLO_COS;
            cmd.dst     = DST_LHS_LD16;
            state_in    = ST_C_M9;
         end
         ST_C_M9: begin
            cmd.mul_sel = MUL_PHI_COS;
            cmd.dst     = DST_RHS_LD;
            state_in    = ST_C_M10;
         end
         ST_C_M10: begin
            cmd.dst  = DST_RHS_ADD_HI;
            state_in = ST_C_DEC;
         end
         ST_C_DEC: begin
            cmd.corner_eval = 1'b1;
            state_in        = ST_IDLE;
         end
         // closed test: first point against last point
         ST_K_RL: begin
            cmd.rd_sel = RD_LAST;
            state_in   = ST_K_LL;
         end
         ST_K_LL: begin
            cmd.ld_b = 1'b1;
            state_in = ST_K_M0;
         end
         ST_K_M0: begin
            cmd.mul_sel = MUL_CLX;
            state_in    = ST_K_M1;
         end
         ST_K_M1: begin
            cmd.mul_sel = MUL_CLY;
            cmd.dst     = DST_S0_LD;
            state_in    = ST_K_M2;
         end
         ST_K_M2: begin
            cmd.mul_sel = MUL_CDCD;
            cmd.dst     = DST_S0_ADD;
            state_in    = ST_K_M3;
         end
         ST_K_M3: begin
            cmd.dst  = DST_S1_LD;
            state_in = ST_K_DEC;
         end
         ST_K_DEC: begin
            if (status.closed && status.four_corners) begin
               state_in = ST_Q_M0;
            end else begin
               cmd.set_class = 1'b1;
               cmd.cls_sel   = CSEL_GEOM;
               state_in      = ST_OUT;
            end
         end
         // square test on the two diagonals
         ST_Q_M0: begin
            cmd.mul_sel = MUL_D02X;
            state_in    = ST_Q_M1;
         end
         ST_Q_M1: begin
            cmd.mul_sel = MUL_D02Y;
            cmd.dst     = DST_S0_LD;
            state_in    = ST_Q_M2;
         end
         ST_Q_M2: begin
            cmd.mul_sel = MUL_D13X;
            cmd.dst     = DST_S0_ADD;
            state_in    = ST_Q_M3;
         end
         ST_Q_M3: begin
            cmd.mul_sel = MUL_D13Y;
            cmd.dst     = DST_S1_LD;
            state_in    = ST_Q_M4;
         end
         ST_Q_M4: begin
            cmd.mul_sel = MUL_TT;
            cmd.dst     = DST_S1_ADD;
            state_in    = ST_Q_M5;
         end
         ST_Q_M5: begin
            cmd.dst  = DST_S2_LD;
            state_in = ST_Q_M6;
         end
         ST_Q_M6: begin
            cmd.mul_sel = MUL_DD;
            state_in    = ST_Q_M7;
         end
         ST_Q_M7: begin
            cmd.mul_sel = MUL_T2Q;
            cmd.dst     = DST_LHS_LD;
            state_in    = ST_Q_M8;
         end
         ST_Q_M8: begin
            cmd.dst  = DST_RHS_LD4;
            state_in = ST_Q_DEC;
         end
         ST_Q_DEC: begin
            cmd.set_class = 1'b1;
            cmd.cls_sel   = CSEL_QUAD;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/ssc_dp.sv =====
`include "stroke_shape_classifier_core_assert.svh"

module ssc_dp import ssc_pkg::*; #(
   parameter int POINT_CAPACITY = DEF_POINT_CAPACITY,
   parameter int CORNER_SPAN    = DEF_CORNER_SPAN,
   parameter int CORNER_LIMIT   = DEF_CORNER_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] x_coord,
   input  logic [COORD_BITS-1:0] y_coord,
   input  cfg_type               cfg,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [CLASS_W-1:0]    shape_class,
   output logic [TOTAL_W-1:0]    corner_total
);

   localparam int RING_DEPTH = 2 * CORNER_SPAN + 1;
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int CW         = $clog2(POINT_CAPACITY + 1);
   localparam int TW         = $clog2(CORNER_LIMIT + 1);

   // stroke state
   point_type             ring_mem [RING_DEPTH];
   point_type             rd_ff;
   logic [AW-1:0]         wptr_ff;
   logic [AW-1:0]         rd_addr;
   logic [AW:0]           b_sum;
   logic [AW-1:0]         b_idx;
   logic [CW-1:0]         count_ff;
   logic                  pen_ff;
   logic [TW-1:0]         tally_ff;
   point_type             first_ff;
   point_type             corner_ff [4];
   logic [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   point_type             pa_ff, pb_ff, pc_ff;
   class_type             class_ff;
   point_type             pt_in;

   // arithmetic
   logic        [SQ_W-1:0]     s0_ff, s1_ff;
   logic signed [DOT_W-1:0]    s2_ff;
   logic        [2*SQ_W-1:0]   p_ff;
   logic        [CMP_W-1:0]    lhs_ff, rhs_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [MUL_W-1:0]    op_a, op_b;
   logic signed [COORD_BITS:0] ux, uy, vx, vy, clx, cly, d02x, d02y, d13x, d13y;
   logic        [SQ_W-1:0]     mag, big, sml, diff, t2u;
   logic signed [MUL_W-1:0]    dd;
   logic                       corner_hit, square_hit;
   logic [COORD_BITS-1:0]      box_w, box_h;
   logic [COORD_BITS+1:0]      w2, w3, h2, h3;
   class_type                  geom_class;

   function automatic logic signed [COORD_BITS:0] sdiff(
      input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] b);
      sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   assign pt_in.x = x_coord;
   assign pt_in.y = y_coord;

   // ring addressing: a is one past the newest slot, b is a span ahead of a
   assign b_sum = {1'b0, wptr_ff} + (AW+1)'(CORNER_SPAN);
   assign b_idx = (b_sum >= (AW+1)'(RING_DEPTH)) ? AW'(b_sum - (AW+1)'(RING_DEPTH))
                                                 : b_sum[AW-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_A:    rd_addr = wptr_ff;
         RD_B:    rd_addr = b_idx;
         RD_LAST: rd_addr = (wptr_ff == '0) ? AW'(RING_DEPTH - 1) : wptr_ff - AW'(1);
         default: rd_addr = wptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         ring_mem[wptr_ff] <= pt_in;
      end
      rd_ff <= ring_mem[rd_addr];
   end

   assign ux   = sdiff(pa_ff.x, pb_ff.x);
   assign uy   = sdiff(pa_ff.y, pb_ff.y);
   assign vx   = sdiff(pc_ff.x, pb_ff.x);
   assign vy   = sdiff(pc_ff.y, pb_ff.y);
   assign clx  = sdiff(first_ff.x, pb_ff.x);
   assign cly  = sdiff(first_ff.y, pb_ff.y);
   assign d02x = sdiff(corner_ff[0].x, corner_ff[2].x);
   assign d02y = sdiff(corner_ff[0].y, corner_ff[2].y);
   assign d13x = sdiff(corner_ff[1].x, corner_ff[3].x);
   assign d13y = sdiff(corner_ff[1].y, corner_ff[3].y);

   assign mag  = s2_ff[DOT_W-1] ? SQ_W'(-s2_ff) : SQ_W'(s2_ff);
   assign big  = (s0_ff < s1_ff) ? s1_ff : s0_ff;
   assign sml  = (s0_ff < s1_ff) ? s0_ff : s1_ff;
   assign diff = big - sml;
   assign t2u  = s2_ff[SQ_W-1:0];
   assign dd   = $signed({1'b0, diff}) - $signed({1'b0, t2u});

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.mul_sel)
         MUL_NONE: ;
         MUL_UXUX:   begin op_a = MUL_W'(ux);   op_b = MUL_W'(ux);   end
         MUL_UYUY:   begin op_a = MUL_W'(uy);   op_b = MUL_W'(uy);   end
         MUL_VXVX:   begin op_a = MUL_W'(vx);   op_b = MUL_W'(vx);   end
         MUL_VYVY:   begin op_a = MUL_W'(vy);   op_b = MUL_W'(vy);   end
         MUL_UXVX:   begin op_a = MUL_W'(ux);   op_b = MUL_W'(vx);   end
         MUL_UYVY:   begin op_a = MUL_W'(uy);   op_b = MUL_W'(vy);   end
         MUL_UUVV: begin
            op_a = $signed({1'b0, s0_ff});
            op_b = $signed({1'b0, s1_ff});
         end
         MUL_MAGMAG: begin
            op_a = $signed({1'b0, mag});
            op_b = $signed({1'b0, mag});
         end
         MUL_PLO_COS: begin
            op_a = $signed({1'b0, p_ff[SQ_W-1:0]});
            op_b = $signed({{(MUL_W-COS_W){1'b0}}, cfg.corner_cos_sq_q16});
         end
         MUL_PHI_COS: begin
            op_a = $signed({1'b0, p_ff[2*SQ_W-1:SQ_W]});
            op_b = $signed({{(MUL_W-COS_W){1'b0}}, cfg.corner_cos_sq_q16});
         end
         MUL_D02X:   begin op_a = MUL_W'(d02x); op_b = MUL_W'(d02x); end
         MUL_D02Y:   begin op_a = MUL_W'(d02y); op_b = MUL_W'(d02y); end
         MUL_D13X:   begin op_a = MUL_W'(d13x); op_b = MUL_W'(d13x); end
         MUL_D13Y:   begin op_a = MUL_W'(d13y); op_b = MUL_W'(d13y); end
         MUL_TT: begin
            op_a = $signed({{(MUL_W-CFG_W){1'b0}}, cfg.square_tolerance});
            op_b = $signed({{(MUL_W-CFG_W){1'b0}}, cfg.square_tolerance});
         end
         MUL_DD:     begin op_a = dd;           op_b = dd;           end
         MUL_T2Q: begin
            op_a = $signed({1'b0, t2u});
            op_b = $signed({1'b0, sml});
         end
         MUL_CLX:    begin op_a = MUL_W'(clx);  op_b = MUL_W'(clx);  end
         MUL_CLY:    begin op_a = MUL_W'(cly);  op_b = MUL_W'(cly);  end
         MUL_CDCD: begin
            op_a = $signed({{(MUL_W-CFG_W){1'b0}}, cfg.close_distance});
            op_b = $signed({{(MUL_W-CFG_W){1'b0}}, cfg.close_distance});
         end
         default: ;
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.dst)
         DST_NONE: ;
         DST_S0_LD:      s0_ff  <= prod_ff[SQ_W-1:0];
         DST_S0_ADD:     s0_ff  <= s0_ff + prod_ff[SQ_W-1:0];
         DST_S1_LD:      s1_ff  <= prod_ff[SQ_W-1:0];
         DST_S1_ADD:     s1_ff  <= s1_ff + prod_ff[SQ_W-1:0];
         DST_S2_LD:      s2_ff  <= prod_ff[DOT_W-1:0];
         DST_S2_ADD:     s2_ff  <= s2_ff + prod_ff[DOT_W-1:0];
         DST_P_LD:       p_ff   <= prod_ff[2*SQ_W-1:0];
         DST_LHS_LD16:   lhs_ff <= {prod_ff[2*SQ_W-1:0], {COS_W{1'b0}}};
         DST_LHS_LD:     lhs_ff <= CMP_W'(prod_ff[2*SQ_W-1:0]);
         DST_RHS_LD:     rhs_ff <= CMP_W'(prod_ff[2*SQ_W-1:0]);
         DST_RHS_ADD_HI: rhs_ff <= rhs_ff + {prod_ff[SQ_W+COS_W-1:0], {SQ_W{1'b0}}};
         DST_RHS_LD4:    rhs_ff <= CMP_W'({prod_ff[2*SQ_W-1:0], 2'b00});
         default: ;
      endcase
   end

   // zero-length arms never count; an acute or right angle always does
   assign corner_hit = (s0_ff != '0) && (s1_ff != '0) &&
                       (!s2_ff[DOT_W-1] || (lhs_ff < rhs_ff));
   assign square_hit = (diff < t2u) || (lhs_ff < rhs_ff);

   // open stroke: aspect of the bounding box
   assign box_w = max_x_ff - min_x_ff;
   assign box_h = max_y_ff - min_y_ff;
   assign w2    = {1'b0, box_w, 1'b0};
   assign h2    = {1'b0, box_h, 1'b0};
   assign w3    = w2 + (COORD_BITS+2)'(box_w);
   assign h3    = h2 + (COORD_BITS+2)'(box_h);

   always_comb begin
      if (s0_ff < s1_ff) begin
         priority if (32'(tally_ff) == 3) geom_class = CLS_TRIANGLE;
         else if (32'(tally_ff) == 5)     geom_class = CLS_PENTAGON;
         else                             geom_class = CLS_UNKNOWN_CLOSED;
      end else begin
         priority if (h2 > w3) geom_class = CLS_LETTER_I;
         else if (w2 > h3)     geom_class = CLS_Z_DASH;
         else if (box_w > cfg.round_min_size && box_h > cfg.round_min_size)
            geom_class = CLS_LETTER_O;
         else
            geom_class = CLS_UNKNOWN_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         pc_ff <= pt_in;
         if (count_ff == '0) begin
            first_ff <= pt_in;
         end
      end
      if (cmd.ld_a) begin
         pa_ff <= rd_ff;
      end
      if (cmd.ld_b) begin
         pb_ff <= rd_ff;
      end
      if (cmd.corner_eval && corner_hit && 32'(tally_ff) < 4) begin
         corner_ff[tally_ff[1:0]] <= pb_ff;
      end
      if (cmd.set_class) begin
         unique case (cmd.cls_sel)
            CSEL_SHORT: class_ff <= CLS_TOO_SHORT;
            CSEL_GEOM:  class_ff <= geom_class;
            CSEL_QUAD:  class_ff <= square_hit ? CLS_SQUARE : CLS_RECT_RHOMBUS;
            default:    class_ff <= CLS_TOO_SHORT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff   <= 1'b0;
         count_ff <= '0;
         wptr_ff  <= '0;
         tally_ff <= '0;
         min_x_ff <= '1;
         min_y_ff <= '1;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else begin
         if (cmd.clear) begin
            pen_ff   <= 1'b1;
            count_ff <= '0;
            wptr_ff  <= '0;
            tally_ff <= '0;
            min_x_ff <= '1;
            min_y_ff <= '1;
            max_x_ff <= '0;
            max_y_ff <= '0;
         end
         if (cmd.pen_up) begin
            pen_ff <= 1'b0;
         end
         if (cmd.add) begin
            count_ff <= count_ff + CW'(1);
            wptr_ff  <= (wptr_ff == AW'(RING_DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
            if (x_coord < min_x_ff) min_x_ff <= x_coord;
            if (x_coord > max_x_ff) max_x_ff <= x_coord;
            if (y_coord < min_y_ff) min_y_ff <= y_coord;
            if (y_coord > max_y_ff) max_y_ff <= y_coord;
         end
         if (cmd.corner_eval && corner_hit) begin
            tally_ff <= tally_ff + TW'(1);
         end
      end
   end

   assign status.pen_active   = pen_ff;
   assign status.can_add      = 32'(count_ff) < 32'(POINT_CAPACITY);
   assign status.span_full    = 32'(count_ff) >= 32'(2 * CORNER_SPAN);
   assign status.tally_open   = 32'(tally_ff) < 32'(CORNER_LIMIT);
   assign status.too_short    = (count_ff == '0) ||
                                (32'(count_ff) < 32'(cfg.min_points));
   assign status.closed       = s0_ff < s1_ff;
   assign status.four_corners = 32'(tally_ff) == 4;

   assign shape_class  = class_ff;
   assign corner_total = TOTAL_W'(tally_ff);

   `SSC_ASSERT_IMPLIES(a_tally_cap, clock, reset, 1'b1, 32'(tally_ff) <= 32'(CORNER_LIMIT), "corner tally past its limit")
   `SSC_ASSERT_NEXT(a_tally_step, clock, reset, cmd.corner_eval && corner_hit, tally_ff == $past(tally_ff) + TW'(1), "corner not counted")
   `SSC_ASSERT_NEXT(a_clear, clock, reset, cmd.clear, count_ff == '0 && tally_ff == '0 && pen_ff, "pen down did not restart the stroke")
   `SSC_ASSERT_IMPLIES(a_eval_room, clock, reset, cmd.corner_eval, 32'(tally_ff) < 32'(CORNER_LIMIT), "corner test with the tally full")

endmodule
